[src/frb_pkg.sv]
// Shared constants and controller/datapath interface types for the flit
// retransmission buffer. No dependencies; imported by every module in src.
package frb_pkg;

    // Store geometry and field widths.
    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMIT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W     = 16;
    localparam int PAYLOAD_W = 64;
    localparam int KEEP_W    = 5;
    localparam int DATA_W    = KEY_W + PAYLOAD_W;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_KEEP_COUNT = 1'b0;
    localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = KEEP_W'(10);

    // Input kind carried in the func field.
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_ARQ  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted input transaction
        logic search;    // compare the latched key against the store
        logic forward;   // send the new flit and push a copy into the store
        logic replay;    // send the matching stored copy
    } frb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func;      // kind of the latched item
        logic arq_mode;  // mode bit of the latched item
        logic hit;       // registered search result
        logic out_free;  // output register can take a new result this cycle
    } frb_status_t;

endpackage

[src/frb_datapath.sv]
// Datapath of the flit retransmission buffer: input item register, shift
// store of kept copies with valid bits, key search and output register.
// Depends on frb_pkg.
module frb_datapath
    import frb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  frb_cmd_t              cmd,
    output frb_status_t           status,
    input  logic [KEEP_W-1:0]     keep_count,
    input  logic                  in_func,
    input  logic [KEY_W-1:0]      in_key,
    input  logic                  in_arq_mode,
    input  logic [PAYLOAD_W-1:0]  in_payload,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KEY_W-1:0]      out_key,
    output logic [PAYLOAD_W-1:0]  out_payload,
    output logic                  out_replay
);

    // Latched input item.
    logic                  item_func_reg;
    logic [KEY_W-1:0]      item_key_reg;
    logic                  item_mode_reg;
    logic [PAYLOAD_W-1:0]  item_payload_reg;

    // Kept copies, slot 0 the newest.
    logic [KEY_W-1:0]      store_key_reg     [DEPTH];
    logic [PAYLOAD_W-1:0]  store_payload_reg [DEPTH];
    logic [DEPTH-1:0]      store_valid_reg;
    logic [DEPTH-1:0]      store_valid_next;

    // Search result.
    logic                  hit_reg;
    logic                  hit_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [KEY_W-1:0]      out_key_reg;
    logic [PAYLOAD_W-1:0]  out_payload_reg;
    logic                  out_replay_reg;

    logic [LIMIT_W-1:0]    limit;

    // Capture the accepted item.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_func_reg    <= in_func;
            item_key_reg     <= in_key;
            item_mode_reg    <= in_arq_mode;
            item_payload_reg <= in_payload;
        end
    end

    // Newest valid slot holding the requested key; lower slots take priority.
    always_comb begin
        hit_next = 1'b0;
        idx_next = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (store_valid_reg[i] && (store_key_reg[i] == item_key_reg)) begin
                hit_next = 1'b1;
                idx_next = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search) begin
            hit_reg <= hit_next;
            idx_reg <= idx_next;
        end
    end

    // Number of slots kept, clamped to the store depth.
    always_comb begin
        if (32'(keep_count) > 32'(DEPTH)) begin
            limit = LIMIT_W'(DEPTH);
        end else begin
            limit = LIMIT_W'(keep_count);
        end
    end

    // A push moves every copy one slot older and drops those beyond the limit.
    always_comb begin
        store_valid_next = store_valid_reg;
        if (cmd.forward) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (32'(i) < 32'(limit)) begin
                    store_valid_next[i] = (i == 0) ? 1'b1 : store_valid_reg[(i > 0) ? i - 1 : 0];
                end else begin
                    store_valid_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_valid_reg <= '0;
        end else begin
            store_valid_reg <= store_valid_next;
        end
    end

    // Copy contents shift on every push; validity alone decides what is held.
    always_ff @(posedge aclk) begin
        if (cmd.forward) begin
            store_key_reg[0]     <= item_key_reg;
            store_payload_reg[0] <= item_payload_reg;
            for (int i = 1; i < DEPTH; i++) begin
                store_key_reg[i]     <= store_key_reg[i-1];
                store_payload_reg[i] <= store_payload_reg[i-1];
            end
        end
    end

    // Output register: loaded by a forward or replay, emptied by the receiver.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.forward || cmd.replay) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.forward) begin
            out_key_reg     <= item_key_reg;
            out_payload_reg <= item_payload_reg;
            out_replay_reg  <= 1'b0;
        end else if (cmd.replay) begin
            out_key_reg     <= store_key_reg[idx_reg];
            out_payload_reg <= store_payload_reg[idx_reg];
            out_replay_reg  <= 1'b1;
        end
    end

    assign status.func     = item_func_reg;
    assign status.arq_mode = item_mode_reg;
    assign status.hit      = hit_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign out_replay  = out_replay_reg;

endmodule

[src/frb_controller.sv]
// Controller of the flit retransmission buffer: sequences accept, search and
// issue for one item at a time. Depends on frb_pkg.
module frb_controller
    import frb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  frb_status_t  status,
    output frb_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_ISSUE  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (status.func == FUNC_DATA) begin
                    // A new flit waits here until the output register is free.
                    if (status.out_free) begin
                        cmd.forward = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else if (status.arq_mode && status.hit) begin
                    if (status.out_free) begin
                        cmd.replay = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    // Request without a held copy, or not in ARQ mode: dropped.
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/flit_retransmission_buffer_top.sv]
// Flit retransmission buffer: the sender side of an ARQ link.
//
// Input channel (s_): data flits (func 0) are forwarded and a copy is kept;
// ARQ requests (func 1) resend the newest kept copy under the requested key.
// Output channel (m_): forwarded flits and replayed copies, m_tuser marking
// replays. APB register 0 (keep_count), clamped to 16, sets how many recent
// flits are kept. Write it only while the block is idle; nothing checks it.
//
// Each item passes through accept, key search over the 16 slots and issue,
// in the controller's sequence; a new input transaction is accepted only
// once the last item has left the issue step. A request with no held copy,
// or whose mode is not ARQ, produces nothing.
// The output register lets the next item be accepted and searched while a
// result still waits; when the receiver stalls, the following result holds
// in the issue step and s_tready stays low until the output register frees.
// Reset clears the valid bits of all kept copies, the output register and
// the controller, and restores keep_count to 10.
// Depends on frb_pkg, frb_controller and frb_datapath.
module flit_retransmission_buffer_top
    import frb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // flit_key, flit_payload
    input  logic [1:0]             s_tuser,   // func, mode_is_arq
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // out_key, out_payload
    output logic [0:0]             m_tuser,   // is_replay
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    frb_cmd_t            cmd;
    frb_status_t         status;
    logic [KEEP_W-1:0]   keep_count_reg;
    logic [KEY_W-1:0]    out_key;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                out_replay;
    logic                cfg_write;

    // Configuration register; only the register index is decoded.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= KEEP_COUNT_RESET;
        end else if (cfg_write && (paddr[2] == REG_KEEP_COUNT)) begin
            keep_count_reg <= pwdata[KEEP_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_KEEP_COUNT) begin
            prdata = APB_DATA_W'(keep_count_reg);
        end else begin
            prdata = '0;
        end
    end

    frb_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frb_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .keep_count  (keep_count_reg),
        .in_func     (s_tuser[0]),
        .in_key      (s_tdata[KEY_W-1:0]),
        .in_arq_mode (s_tuser[1]),
        .in_payload  (s_tdata[DATA_W-1:KEY_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_key     (out_key),
        .out_payload (out_payload),
        .out_replay  (out_replay)
    );

    assign m_tdata = {out_payload, out_key};
    assign m_tuser = out_replay;

`ifndef SYNTHESIS
    // At most one command is issued in any cycle.
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.search, cmd.forward, cmd.replay}))
        else $error("controller issued several commands at once");

    // An accepted transaction is always searched in the next cycle.
    a_capture_then_search: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.search)
        else $error("accepted item was not searched");

    // A result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.forward || cmd.replay) |-> !(m_tvalid && !m_tready))
        else $error("output register overwritten while stalled");

    // A replay is issued only for an ARQ-mode request that hit.
    a_replay_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.replay |-> (status.hit && status.arq_mode && status.func == FUNC_ARQ))
        else $error("replay without a matching held copy");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench for flit_retransmission_buffer_top: drives flits and
// ARQ requests, predicts the forwarded and replayed flits, and compares them.
// Depends on frb_pkg and the top level of the block; needs no other files.
`timescale 1ns / 100ps

module tb
    import frb_pkg::*;
();

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 120;
    localparam int RECENT_KEYS    = 24;
    localparam int N_PHASES       = 9;
    localparam logic [APB_ADDR_W-1:0] KEEP_ADDR   = APB_ADDR_W'(REG_KEEP_COUNT) << 2;
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4);

    typedef struct packed {
        logic                 func;
        logic [KEY_W-1:0]     key;
        logic                 arq_mode;
        logic [PAYLOAD_W-1:0] payload;
    } flit_in_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 replay;
    } flit_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;   // flit_key, flit_payload
    logic [1:0]            s_tuser = '0;   // func, mode_is_arq
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;        // out_key, out_payload
    logic [0:0]            m_tuser;        // is_replay
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    flit_retransmission_buffer_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Stimulus queue, outstanding outgoing flits, and the predicted buffer state.
    flit_in_t             pending_flits[$];
    flit_out_t            flits_due[$];
    logic [KEY_W-1:0]     recent_keys[$];
    logic [KEY_W-1:0]     copy_key[DEPTH];
    logic [PAYLOAD_W-1:0] copy_payload[DEPTH];
    bit                   copy_valid[DEPTH];
    logic [KEEP_W-1:0]    keep_pred = KEEP_COUNT_RESET;

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  take_gap = 0;
    bit  idle_on = 1'b1;
    bit  in_fire = 1'b0;
    flit_in_t  next_flit;
    flit_in_t  seen_flit;
    flit_out_t seen_out;
    flit_out_t due_out;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Works out what the link sends for one accepted transaction and updates the
    // kept copies; returns 0 when nothing is sent.
    function automatic bit predict_link_out(input flit_in_t f, output flit_out_t o);
        int held;
        held = (keep_pred > DEPTH) ? DEPTH : int'(keep_pred);
        o = '0;
        if (f.func == FUNC_DATA) begin
            if (held == 0) begin
                for (int i = 0; i < DEPTH; i++) copy_valid[i] = 1'b0;
            end else begin
                for (int i = DEPTH - 1; i > 0; i--) begin
                    copy_key[i]     = copy_key[i-1];
                    copy_payload[i] = copy_payload[i-1];
                    copy_valid[i]   = copy_valid[i-1];
                end
                copy_key[0]     = f.key;
                copy_payload[0] = f.payload;
                copy_valid[0]   = 1'b1;
                for (int i = held; i < DEPTH; i++) copy_valid[i] = 1'b0;
            end
            o = '{key: f.key, payload: f.payload, replay: 1'b0};
            return 1'b1;
        end
        if (!f.arq_mode) return 1'b0;
        // The newest matching copy sits in the lowest slot.
        for (int i = 0; i < DEPTH; i++) begin
            if (copy_valid[i] && copy_key[i] == f.key) begin
                o = '{key: copy_key[i], payload: copy_payload[i], replay: 1'b1};
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error at %0t: %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Monitor: checks each output transaction, predicts each input transaction
    // and follows register writes.
    always @(posedge aclk) begin
        in_fire <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen_out = '{key: m_tdata[KEY_W-1:0], payload: m_tdata[DATA_W-1:KEY_W],
                             replay: m_tuser[0]};
                if (flits_due.size() == 0) begin
                    report_mismatch("result with none due", 64'(seen_out.key),
                                    seen_out.payload);
                end else begin
                    due_out = flits_due.pop_front();
                    if (seen_out.key !== due_out.key)
                        report_mismatch("out_key", 64'(seen_out.key), 64'(due_out.key));
                    if (seen_out.payload !== due_out.payload)
                        report_mismatch("out_payload", seen_out.payload, due_out.payload);
                    if (seen_out.replay !== due_out.replay)
                        report_mismatch("is_replay", 64'(seen_out.replay),
                                        64'(due_out.replay));
                end
            end
            if (s_tvalid && s_tready) begin
                seen_flit = '{func: s_tuser[0], key: s_tdata[KEY_W-1:0],
                              arq_mode: s_tuser[1], payload: s_tdata[DATA_W-1:KEY_W]};
                if (predict_link_out(seen_flit, due_out)) flits_due.push_back(due_out);
            end
            if (psel && penable && pwrite && pready && paddr == KEEP_ADDR)
                keep_pred = pwdata[KEEP_W-1:0];
        end
    end

    // Driver: presents queued flits, holding each until it is taken, with
    // random bursts of idle cycles.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // The current transaction has not been taken yet.
        end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_flits.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 12);
            s_tvalid <= 1'b0;
        end else begin
            next_flit = pending_flits.pop_front();
            s_tdata  <= {next_flit.payload, next_flit.key};
            s_tuser  <= {next_flit.arq_mode, next_flit.func};
            s_tvalid <= 1'b1;
        end
    end

    // Receiver: accepts results, stalling in random bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (take_gap != 0) begin
            take_gap <= take_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            take_gap <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_flit(input logic func, input logic [KEY_W-1:0] key,
                             input logic arq_mode, input logic [PAYLOAD_W-1:0] payload);
        pending_flits.push_back('{func: func, key: key, arq_mode: arq_mode, payload: payload});
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        // Half the keys come from a narrow range so that duplicates occur.
        return ($urandom_range(0, 1) != 0) ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom);
    endfunction

    // Requests, mostly for recently sent keys, mixed with new flits; each phase
    // opens with requests so copies above a lowered count are still asked for.
    task automatic push_random_flits(input int count);
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 arq_mode;
        for (int n = 0; n < count; n++) begin
            payload  = {$urandom, $urandom};
            arq_mode = ($urandom_range(0, 7) != 0);
            if (n < 4 || $urandom_range(0, 99) < 45) begin
                if (recent_keys.size() != 0 && $urandom_range(0, 3) != 0)
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    key = random_key();
                push_flit(FUNC_ARQ, key, arq_mode, payload);
            end else begin
                key = random_key();
                push_flit(FUNC_DATA, key, 1'($urandom_range(0, 1)), payload);
                recent_keys.push_back(key);
                if (recent_keys.size() > RECENT_KEYS) void'(recent_keys.pop_front());
            end
        end
    endtask

    // Waits until every queued flit is taken and every due result has arrived,
    // then lets a dropped request finish inside the block. The check runs at
    // the rising edge, where the driver's outputs and queue are stable.
    task automatic drain_link();
        @(posedge aclk);
        while (pending_flits.size() != 0 || s_tvalid || flits_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sequence: reset, directed checks at the reset keep count, then random
    // phases across several keep counts.
    initial begin
        int keep_plan[N_PHASES];
        keep_plan = '{16, 3, 0, 31, 1, 17, 2, 10, 5};
        keep_plan[6] = $urandom_range(2, 15);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // A write to an unused address must leave the keep count at ten.
        apb_write(UNUSED_ADDR, 32'd2);

        // Extreme keys and payloads; the mode bit on a data flit is ignored.
        push_flit(FUNC_DATA, 16'h0000, 1'b0, 64'h0);
        push_flit(FUNC_DATA, 16'hFFFF, 1'b1, '1);
        push_flit(FUNC_DATA, 16'h1234, 1'b0, 64'hA5A5_A5A5_A5A5_A5A5);
        push_flit(FUNC_DATA, 16'h1234, 1'b0, 64'h5A5A_5A5A_5A5A_5A5A);
        // The newest of two copies under one key is replayed.
        push_flit(FUNC_ARQ, 16'h1234, 1'b1, 64'h0);
        push_flit(FUNC_ARQ, 16'h0000, 1'b1, '1);
        push_flit(FUNC_ARQ, 16'hFFFF, 1'b1, 64'h0);
        // A request outside ARQ mode is dropped, and an unknown key misses.
        push_flit(FUNC_ARQ, 16'hFFFF, 1'b0, 64'h0);
        push_flit(FUNC_ARQ, 16'h4321, 1'b1, 64'h0);
        push_flit(FUNC_DATA, 16'h8001, 1'b0, 64'h8000_0000_0000_0001);
        // Overfill the store so the oldest copies are evicted.
        for (int i = 0; i < 8; i++)
            push_flit(FUNC_DATA, KEY_W'(16'h0100 + i), 1'b0, {$urandom, $urandom});
        push_flit(FUNC_ARQ, 16'h0000, 1'b1, 64'h0);
        push_flit(FUNC_ARQ, 16'hFFFF, 1'b1, 64'h0);
        push_flit(FUNC_ARQ, 16'h1234, 1'b1, 64'h0);
        push_flit(FUNC_ARQ, 16'h0107, 1'b1, 64'h0);
        drain_link();

        // Random phases; upper data bits of each write carry noise.
        for (int p = 0; p < N_PHASES; p++) begin
            apb_write(KEEP_ADDR, ($urandom & ~32'h1F) | 32'(keep_plan[p]));
            idle_on = (p != N_PHASES - 1) && (p % 3 != 2);
            push_random_flits(PHASE_ITEMS);
            drain_link();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
